// ===== rtl/segregated_fit_heap_allocator_core_defines.svh =====
// Assertion macros for the segregated-fit heap allocator.
// Used by segregated_fit_heap_allocator_core.sv; no other dependencies.
`ifndef SEGREGATED_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define SEGREGATED_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SFHA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfha_pkg.sv =====
// Shared types, constants and helpers for the segregated-fit heap allocator.
// No dependencies; used by sfha_heap_mem and segregated_fit_heap_allocator_core.
package sfha_pkg;

  localparam int DEF_HEAP_BYTES   = 65536;
  localparam int DEF_SIZE_CLASSES = 32;

  localparam logic [31:0] HEADER_BYTES = 32'd12;
  localparam logic [31:0] MIN_PAYLOAD  = 32'd8;
  localparam logic [31:0] CHUNK_MIN    = 32'd20;
  localparam logic [31:0] ALIGN_MASK   = 32'd3;
  localparam logic [31:0] FREE_SAT     = 32'h0001_FFFF;
  localparam logic [16:0] LENGTH_RESET = 17'h1_0000;

  // Word slots inside a chunk header
  localparam logic [2:0] W_NEXT  = 3'd0;
  localparam logic [2:0] W_PREV  = 3'd1;
  localparam logic [2:0] W_USED  = 3'd2;
  localparam logic [2:0] W_FNEXT = 3'd3;
  localparam logic [2:0] W_FPREV = 3'd4;

  // Request codes
  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_HEAP_BASE   = 1'b0;
  localparam logic CFG_HEAP_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] request_bytes;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] data_address;
    logic [16:0] free_bytes;
  } rsp_t;

  // One heap memory access: byte offset of a chunk plus header word slot
  typedef struct packed {
    logic        we;
    logic        re;
    logic [31:0] off;
    logic [2:0]  slot;
    logic [31:0] wdata;
  } mem_req_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DONE, ST_OK,
    ST_I_CHK, ST_I_WR, ST_I_FIN,
    ST_A_SIZE, ST_A_FIND, ST_A_RDN, ST_A_SIZE2, ST_A_SPLIT,
    ST_A_C2N, ST_A_C2P, ST_A_C2U, ST_A_CN, ST_A_NXP, ST_A_USED,
    ST_F_CHK, ST_F_USED, ST_F_NEXT, ST_F_PREV, ST_F_PVN, ST_F_NXP, ST_F_NXU,
    ST_F_RDNN, ST_F_NN, ST_F_NNP, ST_F_RDPU, ST_F_PU, ST_F_RDCN, ST_F_CN,
    ST_F_N2P, ST_F_PUSHPV,
    ST_P_RD, ST_P_LEN, ST_P_SELFP, ST_P_TN, ST_P_CP, ST_P_CN, ST_P_HP, ST_P_FIN,
    ST_U_RD, ST_U_LEN, ST_U_FN, ST_U_FP, ST_U_NXP, ST_U_SN, ST_U_SP,
    ST_R_N, ST_R_P, ST_R_U
  } state_t;

  // Number of significant bits (0 for zero)
  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = 6'(i + 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/segregated_fit_heap_allocator_core.sv =====
// Segregated-fit heap allocator. One request is taken at a time and runs as a sequence of
// single-word accesses to the heap metadata memory (one access per cycle, registered read
// data), so the cost is set by that memory port: an allocation costs more with a split than
// without, a free costs more the more neighbors merge, and the result is handed off last.
// A new request can be taken while the previous result still waits on out_stall. Free
// chunks sit on one list per power-of-two size class; their heads and a nonempty mask are
// in flip-flops, so init clears the mask at once and no clearing pass over the memory is
// run. Depends on sfha_pkg, sfha_heap_mem and segregated_fit_heap_allocator_core_defines.svh.
`include "segregated_fit_heap_allocator_core_defines.svh"

module segregated_fit_heap_allocator_core #(
  parameter int HEAP_BYTES   = sfha_pkg::DEF_HEAP_BYTES,
  parameter int SIZE_CLASSES = sfha_pkg::DEF_SIZE_CLASSES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [31:0]    cfg_wdata,
  input  logic           in_valid,
  output logic           in_stall,
  input  sfha_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_stall,
  output sfha_pkg::rsp_t out_rsp
);

  localparam int WORDS = HEAP_BYTES / 4;
  localparam int OFF_W = $clog2(HEAP_BYTES + 1);
  localparam int CLS_W = $clog2(SIZE_CLASSES);
  localparam logic [32:0] HEAP_BYTES_L = 33'(HEAP_BYTES);
  localparam logic [5:0]  TOP_CLASS    = 6'(SIZE_CLASSES - 1);
  localparam logic [5:0]  NUM_CLASSES  = 6'(SIZE_CLASSES);

  sfha_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [31:0] base_r, base_nxt;
  logic [16:0] length_r, length_nxt;
  logic        init_r, init_nxt;
  logic [31:0] region_r, region_nxt;
  logic [OFF_W-1:0] tail_r, tail_nxt;
  logic [31:0] total_r, total_nxt;
  logic [SIZE_CLASSES-1:0] mask_r, mask_nxt;
  logic [OFF_W-1:0] heads_r [SIZE_CLASSES];

  sfha_pkg::req_t req_r, req_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [32:0] sz_r, sz_nxt;
  logic [5:0]  ncls_r, ncls_nxt;
  logic [31:0] c_r, c_nxt, nx_r, nx_nxt, pv_r, pv_nxt, c2_r, c2_nxt;
  logic [31:0] size2_r, size2_nxt;
  logic [31:0] sc_r, sc_nxt, len_r, len_nxt, ta_r, ta_nxt, tb_r, tb_nxt;
  logic [CLS_W-1:0] cls_r, cls_nxt;
  logic        res_ok_r, res_ok_nxt;
  logic [31:0] res_data_r, res_data_nxt;
  logic        out_valid_r, out_valid_nxt;
  sfha_pkg::rsp_t out_rsp_r, out_rsp_nxt;

  logic             hd_we;
  logic [OFF_W-1:0] hd_wdata;

  sfha_pkg::mem_req_t mem_req;
  logic [31:0]        rdata;

  sfha_heap_mem #(.WORDS(WORDS)) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Payload and size class of the chunk whose next link was just read
  logic [31:0]      len_calc;
  logic [5:0]       len_bits;
  logic [CLS_W-1:0] cls_calc;
  assign len_calc = rdata - sc_r - sfha_pkg::HEADER_BYTES;
  assign len_bits = sfha_pkg::bit_len(len_calc);
  always_comb begin
    if (len_bits <= 6'd1) begin
      cls_calc = '0;
    end else if (len_bits - 6'd1 >= TOP_CLASS) begin
      cls_calc = TOP_CLASS[CLS_W-1:0];
    end else begin
      cls_calc = CLS_W'(len_bits - 6'd1);
    end
  end

  // Lowest nonempty class at or above the requested one
  logic             srch_found;
  logic [CLS_W-1:0] srch_k;
  always_comb begin
    srch_found = 1'b0;
    srch_k     = '0;
    for (int i = 0; i < SIZE_CLASSES; i++) begin
      if (!srch_found && mask_r[i] && (6'(i) >= ncls_r)) begin
        srch_found = 1'b1;
        srch_k     = CLS_W'(i);
      end
    end
  end

  // Single read port on the class heads
  logic [CLS_W-1:0] hd_idx;
  logic [31:0]      hd_val;
  always_comb begin
    priority case (state_r)
      sfha_pkg::ST_A_FIND: hd_idx = srch_k;
      sfha_pkg::ST_P_LEN:  hd_idx = cls_calc;
      default:             hd_idx = cls_r;
    endcase
  end
  assign hd_val = {{(32-OFF_W){1'b0}}, heads_r[hd_idx]};

  // Region check for init
  logic [32:0] i_start, i_end, i_span;
  logic        i_bad;
  assign i_start = ({1'b0, base_r} + 33'd3) & ~33'd3;
  assign i_end   = ({1'b0, base_r} + {16'd0, length_r}) & ~33'd3;
  assign i_span  = i_end - i_start;
  assign i_bad   = (i_end[32] && (i_end[31:0] != 32'd0))
                || (i_end < i_start + 33'd60)
                || (i_span > HEAP_BYTES_L);

  // Rounded allocation size
  logic [32:0] a_round, a_sz;
  assign a_round = ({1'b0, req_r.request_bytes} + 33'd3) & ~33'd3;
  assign a_sz    = (a_round < {1'b0, sfha_pkg::MIN_PAYLOAD}) ?
                   {1'b0, sfha_pkg::MIN_PAYLOAD} : a_round;
  logic [32:0] a_szm1;
  assign a_szm1 = a_sz - 33'd1;

  // Chunk offset named by a free
  logic [31:0] f_c;
  assign f_c = req_r.block_address - region_r - sfha_pkg::HEADER_BYTES;

  logic [31:0] tail32;
  assign tail32 = {{(32-OFF_W){1'b0}}, tail_r};

  // Init layout: two sentinels around one free chunk
  logic [31:0] iw_off, iw_data;
  logic [2:0]  iw_slot;
  always_comb begin
    unique case (step_r)
      4'd0:    begin iw_off = 32'd0; iw_slot = sfha_pkg::W_NEXT; iw_data = sfha_pkg::CHUNK_MIN; end
      4'd1:    begin iw_off = 32'd0; iw_slot = sfha_pkg::W_PREV; iw_data = tail32; end
      4'd2:    begin iw_off = 32'd0; iw_slot = sfha_pkg::W_USED; iw_data = 32'd1; end
      4'd3:    begin iw_off = sfha_pkg::CHUNK_MIN; iw_slot = sfha_pkg::W_NEXT; iw_data = tail32; end
      4'd4:    begin iw_off = sfha_pkg::CHUNK_MIN; iw_slot = sfha_pkg::W_PREV; iw_data = 32'd0; end
      4'd5:    begin iw_off = sfha_pkg::CHUNK_MIN; iw_slot = sfha_pkg::W_USED; iw_data = 32'd0; end
      4'd6:    begin iw_off = tail32; iw_slot = sfha_pkg::W_NEXT; iw_data = 32'd0; end
      4'd7:    begin iw_off = tail32; iw_slot = sfha_pkg::W_PREV; iw_data = sfha_pkg::CHUNK_MIN; end
      default: begin iw_off = tail32; iw_slot = sfha_pkg::W_USED; iw_data = 32'd1; end
    endcase
  end

  assign in_stall = (state_r != sfha_pkg::ST_IDLE);

  // Next state and register updates
  always_comb begin
    logic fail;
    fail          = 1'b0;
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    base_nxt      = base_r;
    length_nxt    = length_r;
    init_nxt      = init_r;
    region_nxt    = region_r;
    tail_nxt      = tail_r;
    total_nxt     = total_r;
    mask_nxt      = mask_r;
    req_nxt       = req_r;
    step_nxt      = step_r;
    sz_nxt        = sz_r;
    ncls_nxt      = ncls_r;
    c_nxt         = c_r;
    nx_nxt        = nx_r;
    pv_nxt        = pv_r;
    c2_nxt        = c2_r;
    size2_nxt     = size2_r;
    sc_nxt        = sc_r;
    len_nxt       = len_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    cls_nxt       = cls_r;
    res_ok_nxt    = res_ok_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    hd_we         = 1'b0;
    hd_wdata      = sc_r[OFF_W-1:0];

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index[0])
        sfha_pkg::CFG_HEAP_BASE:   base_nxt   = cfg_wdata;
        sfha_pkg::CFG_HEAP_LENGTH: length_nxt = cfg_wdata[16:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      sfha_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req;
          unique case (in_req.req_type)
            sfha_pkg::REQ_INIT:  state_nxt = sfha_pkg::ST_I_CHK;
            sfha_pkg::REQ_ALLOC: state_nxt = sfha_pkg::ST_A_SIZE;
            sfha_pkg::REQ_FREE:  state_nxt = sfha_pkg::ST_F_CHK;
            default:             fail = 1'b1;
          endcase
        end
      end
      sfha_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_rsp_nxt.ok           = res_ok_r;
          out_rsp_nxt.data_address = res_data_r;
          out_rsp_nxt.free_bytes   = (total_r > sfha_pkg::FREE_SAT) ?
                                     17'h1_FFFF : total_r[16:0];
          state_nxt                = sfha_pkg::ST_IDLE;
        end
      end
      sfha_pkg::ST_OK: begin
        res_ok_nxt   = 1'b1;
        res_data_nxt = 32'd0;
        state_nxt    = sfha_pkg::ST_DONE;
      end

      // init
      sfha_pkg::ST_I_CHK: begin
        if (i_bad) begin
          fail = 1'b1;
        end else begin
          region_nxt = i_start[31:0];
          tail_nxt   = OFF_W'(i_span - {1'b0, sfha_pkg::CHUNK_MIN});
          mask_nxt   = '0;
          total_nxt  = 32'd0;
          step_nxt   = 4'd0;
          state_nxt  = sfha_pkg::ST_I_WR;
        end
      end
      sfha_pkg::ST_I_WR: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd8) begin
          sc_nxt    = sfha_pkg::CHUNK_MIN;
          ret_nxt   = sfha_pkg::ST_I_FIN;
          state_nxt = sfha_pkg::ST_P_RD;
        end
      end
      sfha_pkg::ST_I_FIN: begin
        init_nxt  = 1'b1;
        state_nxt = sfha_pkg::ST_OK;
      end

      // allocate
      sfha_pkg::ST_A_SIZE: begin
        if (!init_r || (req_r.request_bytes == 32'd0)) begin
          fail = 1'b1;
        end else begin
          sz_nxt    = a_sz;
          ncls_nxt  = sfha_pkg::bit_len(a_szm1[31:0]);
          state_nxt = sfha_pkg::ST_A_FIND;
        end
      end
      sfha_pkg::ST_A_FIND: begin
        if (!srch_found || (ncls_r >= NUM_CLASSES)) begin
          fail = 1'b1;
        end else begin
          c_nxt     = hd_val;
          state_nxt = sfha_pkg::ST_A_RDN;
        end
      end
      sfha_pkg::ST_A_RDN: state_nxt = sfha_pkg::ST_A_SIZE2;
      sfha_pkg::ST_A_SIZE2: begin
        size2_nxt = rdata - c_r - sfha_pkg::HEADER_BYTES;
        sc_nxt    = c_r;
        ret_nxt   = sfha_pkg::ST_A_SPLIT;
        state_nxt = sfha_pkg::ST_U_RD;
      end
      sfha_pkg::ST_A_SPLIT: begin
        if (sz_r + {1'b0, sfha_pkg::CHUNK_MIN} <= {1'b0, size2_r}) begin
          c2_nxt    = c_r + sfha_pkg::HEADER_BYTES + sz_r[31:0];
          state_nxt = sfha_pkg::ST_A_C2N;
        end else begin
          state_nxt = sfha_pkg::ST_A_USED;
        end
      end
      sfha_pkg::ST_A_C2N: begin
        nx_nxt    = rdata;
        state_nxt = sfha_pkg::ST_A_C2P;
      end
      sfha_pkg::ST_A_C2P: state_nxt = sfha_pkg::ST_A_C2U;
      sfha_pkg::ST_A_C2U: state_nxt = sfha_pkg::ST_A_CN;
      sfha_pkg::ST_A_CN:  state_nxt = sfha_pkg::ST_A_NXP;
      sfha_pkg::ST_A_NXP: begin
        sc_nxt    = c2_r;
        ret_nxt   = sfha_pkg::ST_A_USED;
        state_nxt = sfha_pkg::ST_P_RD;
      end
      sfha_pkg::ST_A_USED: begin
        res_ok_nxt   = 1'b1;
        res_data_nxt = region_r + c_r + sfha_pkg::HEADER_BYTES;
        state_nxt    = sfha_pkg::ST_DONE;
      end

      // free
      sfha_pkg::ST_F_CHK: begin
        if (!init_r || (req_r.block_address == 32'd0)) begin
          fail = 1'b1;
        end else if ((f_c[1:0] != 2'd0) || (f_c == 32'd0) || (f_c >= tail32)) begin
          fail = 1'b1;
        end else begin
          c_nxt     = f_c;
          state_nxt = sfha_pkg::ST_F_USED;
        end
      end
      sfha_pkg::ST_F_USED: begin
        if (rdata != 32'd1) fail = 1'b1;
        else state_nxt = sfha_pkg::ST_F_NEXT;
      end
      sfha_pkg::ST_F_NEXT: begin
        nx_nxt    = rdata;
        state_nxt = sfha_pkg::ST_F_PREV;
      end
      sfha_pkg::ST_F_PREV: begin
        pv_nxt = rdata;
        if ((nx_r > tail32) || ({1'b0, nx_r} < {1'b0, c_r} + {1'b0, sfha_pkg::CHUNK_MIN})
            || (rdata >= c_r)) begin
          fail = 1'b1;
        end else begin
          state_nxt = sfha_pkg::ST_F_PVN;
        end
      end
      sfha_pkg::ST_F_PVN: begin
        if (rdata != c_r) fail = 1'b1;
        else state_nxt = sfha_pkg::ST_F_NXP;
      end
      sfha_pkg::ST_F_NXP: begin
        if (rdata != c_r) fail = 1'b1;
        else state_nxt = sfha_pkg::ST_F_NXU;
      end
      sfha_pkg::ST_F_NXU: begin
        if (rdata == 32'd0) begin
          sc_nxt    = nx_r;
          ret_nxt   = sfha_pkg::ST_F_RDNN;
          state_nxt = sfha_pkg::ST_U_RD;
        end else begin
          state_nxt = sfha_pkg::ST_F_RDPU;
        end
      end
      sfha_pkg::ST_F_RDNN: state_nxt = sfha_pkg::ST_F_NN;
      sfha_pkg::ST_F_NN: begin
        c2_nxt    = rdata;
        state_nxt = sfha_pkg::ST_F_NNP;
      end
      sfha_pkg::ST_F_NNP: begin
        sc_nxt    = nx_r;
        ret_nxt   = sfha_pkg::ST_F_RDPU;
        state_nxt = sfha_pkg::ST_R_N;
      end
      sfha_pkg::ST_F_RDPU: state_nxt = sfha_pkg::ST_F_PU;
      sfha_pkg::ST_F_PU: begin
        if (rdata == 32'd0) begin
          sc_nxt    = pv_r;
          ret_nxt   = sfha_pkg::ST_F_RDCN;
          state_nxt = sfha_pkg::ST_U_RD;
        end else begin
          sc_nxt    = c_r;
          ret_nxt   = sfha_pkg::ST_OK;
          state_nxt = sfha_pkg::ST_P_RD;
        end
      end
      sfha_pkg::ST_F_RDCN: state_nxt = sfha_pkg::ST_F_CN;
      sfha_pkg::ST_F_CN: begin
        c2_nxt    = rdata;
        state_nxt = sfha_pkg::ST_F_N2P;
      end
      sfha_pkg::ST_F_N2P: begin
        sc_nxt    = c_r;
        ret_nxt   = sfha_pkg::ST_F_PUSHPV;
        state_nxt = sfha_pkg::ST_R_N;
      end
      sfha_pkg::ST_F_PUSHPV: begin
        sc_nxt    = pv_r;
        ret_nxt   = sfha_pkg::ST_OK;
        state_nxt = sfha_pkg::ST_P_RD;
      end

      // push chunk sc onto its class list
      sfha_pkg::ST_P_RD: state_nxt = sfha_pkg::ST_P_LEN;
      sfha_pkg::ST_P_LEN: begin
        len_nxt = len_calc;
        cls_nxt = cls_calc;
        if (!mask_r[cls_calc]) begin
          state_nxt = sfha_pkg::ST_P_SELFP;
        end else begin
          ta_nxt    = hd_val;
          state_nxt = sfha_pkg::ST_P_TN;
        end
      end
      sfha_pkg::ST_P_SELFP: state_nxt = sfha_pkg::ST_P_FIN;
      sfha_pkg::ST_P_TN: begin
        tb_nxt    = rdata;
        state_nxt = sfha_pkg::ST_P_CP;
      end
      sfha_pkg::ST_P_CP: state_nxt = sfha_pkg::ST_P_CN;
      sfha_pkg::ST_P_CN: state_nxt = sfha_pkg::ST_P_HP;
      sfha_pkg::ST_P_HP: state_nxt = sfha_pkg::ST_P_FIN;
      sfha_pkg::ST_P_FIN: begin
        hd_we           = 1'b1;
        hd_wdata        = sc_r[OFF_W-1:0];
        mask_nxt[cls_r] = 1'b1;
        total_nxt       = total_r + len_r;
        state_nxt       = ret_r;
      end

      // unlink chunk sc from its class list
      sfha_pkg::ST_U_RD: state_nxt = sfha_pkg::ST_U_LEN;
      sfha_pkg::ST_U_LEN: begin
        len_nxt   = len_calc;
        cls_nxt   = cls_calc;
        state_nxt = sfha_pkg::ST_U_FN;
      end
      sfha_pkg::ST_U_FN: begin
        ta_nxt    = rdata;
        state_nxt = sfha_pkg::ST_U_FP;
      end
      sfha_pkg::ST_U_FP: begin
        tb_nxt = rdata;
        if (ta_r == sc_r) begin
          mask_nxt[cls_r] = 1'b0;
          state_nxt       = sfha_pkg::ST_U_SN;
        end else begin
          state_nxt = sfha_pkg::ST_U_NXP;
        end
      end
      sfha_pkg::ST_U_NXP: begin
        if (mask_r[cls_r] && (hd_val == sc_r)) begin
          hd_we    = 1'b1;
          hd_wdata = ta_r[OFF_W-1:0];
        end
        state_nxt = sfha_pkg::ST_U_SN;
      end
      sfha_pkg::ST_U_SN: state_nxt = sfha_pkg::ST_U_SP;
      sfha_pkg::ST_U_SP: begin
        total_nxt = total_r - len_r;
        state_nxt = ret_r;
      end

      // retire header of chunk sc
      sfha_pkg::ST_R_N: state_nxt = sfha_pkg::ST_R_P;
      sfha_pkg::ST_R_P: state_nxt = sfha_pkg::ST_R_U;
      sfha_pkg::ST_R_U: state_nxt = ret_r;
      default:          state_nxt = sfha_pkg::ST_IDLE;
    endcase

    if (fail) begin
      res_ok_nxt   = 1'b0;
      res_data_nxt = 32'd0;
      state_nxt    = sfha_pkg::ST_DONE;
    end
  end

  // Heap memory access for each state
  always_comb begin
    mem_req = '0;
    unique case (state_r)
      sfha_pkg::ST_I_WR: begin
        mem_req.we = 1'b1; mem_req.off = iw_off; mem_req.slot = iw_slot;
        mem_req.wdata = iw_data;
      end
      sfha_pkg::ST_A_RDN, sfha_pkg::ST_A_SPLIT, sfha_pkg::ST_F_USED, sfha_pkg::ST_F_RDCN: begin
        mem_req.re = 1'b1; mem_req.off = c_r; mem_req.slot = sfha_pkg::W_NEXT;
      end
      sfha_pkg::ST_A_C2N: begin
        mem_req.we = 1'b1; mem_req.off = c2_r; mem_req.slot = sfha_pkg::W_NEXT;
        mem_req.wdata = rdata;
      end
      sfha_pkg::ST_A_C2P: begin
        mem_req.we = 1'b1; mem_req.off = c2_r; mem_req.slot = sfha_pkg::W_PREV;
        mem_req.wdata = c_r;
      end
      sfha_pkg::ST_A_C2U: begin
        mem_req.we = 1'b1; mem_req.off = c2_r; mem_req.slot = sfha_pkg::W_USED;
      end
      sfha_pkg::ST_A_CN: begin
        mem_req.we = 1'b1; mem_req.off = c_r; mem_req.slot = sfha_pkg::W_NEXT;
        mem_req.wdata = c2_r;
      end
      sfha_pkg::ST_A_NXP: begin
        mem_req.we = 1'b1; mem_req.off = nx_r; mem_req.slot = sfha_pkg::W_PREV;
        mem_req.wdata = c2_r;
      end
      sfha_pkg::ST_A_USED: begin
        mem_req.we = 1'b1; mem_req.off = c_r; mem_req.slot = sfha_pkg::W_USED;
        mem_req.wdata = 32'd1;
      end
      sfha_pkg::ST_F_CHK: begin
        mem_req.re = 1'b1; mem_req.off = f_c; mem_req.slot = sfha_pkg::W_USED;
      end
      sfha_pkg::ST_F_NEXT: begin
        mem_req.re = 1'b1; mem_req.off = c_r; mem_req.slot = sfha_pkg::W_PREV;
      end
      sfha_pkg::ST_F_PREV: begin
        mem_req.re = 1'b1; mem_req.off = rdata; mem_req.slot = sfha_pkg::W_NEXT;
      end
      sfha_pkg::ST_F_PVN: begin
        mem_req.re = 1'b1; mem_req.off = nx_r; mem_req.slot = sfha_pkg::W_PREV;
      end
      sfha_pkg::ST_F_NXP: begin
        mem_req.re = 1'b1; mem_req.off = nx_r; mem_req.slot = sfha_pkg::W_USED;
      end
      sfha_pkg::ST_F_RDNN: begin
        mem_req.re = 1'b1; mem_req.off = nx_r; mem_req.slot = sfha_pkg::W_NEXT;
      end
      sfha_pkg::ST_F_NN: begin
        mem_req.we = 1'b1; mem_req.off = c_r; mem_req.slot = sfha_pkg::W_NEXT;
        mem_req.wdata = rdata;
      end
      sfha_pkg::ST_F_NNP: begin
        mem_req.we = 1'b1; mem_req.off = c2_r; mem_req.slot = sfha_pkg::W_PREV;
        mem_req.wdata = c_r;
      end
      sfha_pkg::ST_F_RDPU: begin
        mem_req.re = 1'b1; mem_req.off = pv_r; mem_req.slot = sfha_pkg::W_USED;
      end
      sfha_pkg::ST_F_PU: begin
        // used predecessor: plain free of this chunk
        if (rdata != 32'd0) begin
          mem_req.we = 1'b1; mem_req.off = c_r; mem_req.slot = sfha_pkg::W_USED;
        end
      end
      sfha_pkg::ST_F_CN: begin
        mem_req.we = 1'b1; mem_req.off = pv_r; mem_req.slot = sfha_pkg::W_NEXT;
        mem_req.wdata = rdata;
      end
      sfha_pkg::ST_F_N2P: begin
        mem_req.we = 1'b1; mem_req.off = c2_r; mem_req.slot = sfha_pkg::W_PREV;
        mem_req.wdata = pv_r;
      end
      sfha_pkg::ST_P_RD, sfha_pkg::ST_U_RD: begin
        mem_req.re = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_NEXT;
      end
      sfha_pkg::ST_P_LEN: begin
        if (!mask_r[cls_calc]) begin
          mem_req.we = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_FNEXT;
          mem_req.wdata = sc_r;
        end else begin
          mem_req.re = 1'b1; mem_req.off = hd_val; mem_req.slot = sfha_pkg::W_FPREV;
        end
      end
      sfha_pkg::ST_P_SELFP, sfha_pkg::ST_U_SP: begin
        mem_req.we = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_FPREV;
        mem_req.wdata = sc_r;
      end
      sfha_pkg::ST_P_TN: begin
        mem_req.we = 1'b1; mem_req.off = rdata; mem_req.slot = sfha_pkg::W_FNEXT;
        mem_req.wdata = sc_r;
      end
      sfha_pkg::ST_P_CP: begin
        mem_req.we = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_FPREV;
        mem_req.wdata = tb_r;
      end
      sfha_pkg::ST_P_CN: begin
        mem_req.we = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_FNEXT;
        mem_req.wdata = ta_r;
      end
      sfha_pkg::ST_P_HP: begin
        mem_req.we = 1'b1; mem_req.off = ta_r; mem_req.slot = sfha_pkg::W_FPREV;
        mem_req.wdata = sc_r;
      end
      sfha_pkg::ST_U_LEN: begin
        mem_req.re = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_FNEXT;
      end
      sfha_pkg::ST_U_FN: begin
        mem_req.re = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_FPREV;
      end
      sfha_pkg::ST_U_FP: begin
        if (ta_r != sc_r) begin
          mem_req.we = 1'b1; mem_req.off = rdata; mem_req.slot = sfha_pkg::W_FNEXT;
          mem_req.wdata = ta_r;
        end
      end
      sfha_pkg::ST_U_NXP: begin
        mem_req.we = 1'b1; mem_req.off = ta_r; mem_req.slot = sfha_pkg::W_FPREV;
        mem_req.wdata = tb_r;
      end
      sfha_pkg::ST_U_SN: begin
        mem_req.we = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_FNEXT;
        mem_req.wdata = sc_r;
      end
      sfha_pkg::ST_R_N: begin
        mem_req.we = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_NEXT;
        mem_req.wdata = sc_r;
      end
      sfha_pkg::ST_R_P: begin
        mem_req.we = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_PREV;
        mem_req.wdata = sc_r;
      end
      sfha_pkg::ST_R_U: begin
        mem_req.we = 1'b1; mem_req.off = sc_r; mem_req.slot = sfha_pkg::W_USED;
      end
      default: ;
    endcase
  end

  // Class heads (read only where the matching mask bit is set)
  always_ff @(posedge clk) begin
    if (hd_we) begin
      heads_r[cls_r] <= hd_wdata;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfha_pkg::ST_IDLE;
      ret_r       <= sfha_pkg::ST_IDLE;
      base_r      <= 32'd0;
      length_r    <= sfha_pkg::LENGTH_RESET;
      init_r      <= 1'b0;
      region_r    <= 32'd0;
      tail_r      <= '0;
      total_r     <= 32'd0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
      step_r      <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      base_r      <= base_nxt;
      length_r    <= length_nxt;
      init_r      <= init_nxt;
      region_r    <= region_nxt;
      tail_r      <= tail_nxt;
      total_r     <= total_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    sz_r       <= sz_nxt;
    ncls_r     <= ncls_nxt;
    c_r        <= c_nxt;
    nx_r       <= nx_nxt;
    pv_r       <= pv_nxt;
    c2_r       <= c2_nxt;
    size2_r    <= size2_nxt;
    sc_r       <= sc_nxt;
    len_r      <= len_nxt;
    ta_r       <= ta_nxt;
    tb_r       <= tb_nxt;
    cls_r      <= cls_nxt;
    res_ok_r   <= res_ok_nxt;
    res_data_r <= res_data_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Checks
  `SFHA_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall,
    state_r != sfha_pkg::ST_IDLE, "accepted request left the sequencer idle")
  `SFHA_ASSERT_NOW(a_result_from_done, clk, rst_n, $rose(out_valid_r),
    $past(state_r == sfha_pkg::ST_DONE), "result appeared outside result hand-off")
  `SFHA_ASSERT_NOW(a_mem_one_access, clk, rst_n, mem_req.we,
    !mem_req.re, "heap memory read and write in one cycle")

endmodule

// ===== rtl/sfha_heap_mem.sv =====
// Heap word memory: one access per cycle, registered read data.
// Out-of-range words read as zero and ignore writes. Depends on sfha_pkg.
module sfha_heap_mem #(
  parameter int WORDS = sfha_pkg::DEF_HEAP_BYTES / 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfha_pkg::mem_req_t req,
  output logic [31:0]        rdata
);

  localparam int IDX_W = $clog2(WORDS);
  localparam logic [31:0] WORDS_L = 32'(WORDS);

  logic [31:0] mem [WORDS];
  logic [31:0] idx;
  logic        in_range;
  logic [31:0] rd_q_r;
  logic        hit_r;

  // Word index of chunk offset plus header slot
  assign idx      = {2'b00, req.off[31:2]} + {29'd0, req.slot};
  assign in_range = (idx < WORDS_L);

  always_ff @(posedge clk) begin
    if (req.we && in_range) begin
      mem[idx[IDX_W-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r <= mem[idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (req.re) begin
      hit_r <= in_range;
    end
  end

  assign rdata = hit_r ? rd_q_r : 32'd0;

endmodule
